// ===== rtl/mnfm_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI note-on to FM register writes: shared package
// Constants, the pitch table and the types passed between the parser, the
// event queue and the write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mnfm_pkg;

   // MIDI and synth register codes.
   localparam logic [7:0] CMD_NOTE_ON = 8'h90;
   localparam logic [7:0] REG_FNUM_HI = 8'hA4;
   localparam logic [7:0] REG_FNUM_LO = 8'hA0;
   localparam logic [7:0] REG_KEY     = 8'h28;
   localparam logic [7:0] KEY_ON_ALL  = 8'hF0;
   localparam logic [7:0] KEY_OFF_ALL = 8'h00;
   localparam logic [7:0] BLOCK_BITS  = 8'h10;

   // Octave handling: octave = note / 12 through a reciprocal multiply,
   // exact for every 8-bit note.
   localparam logic [4:0]  OCTAVE_MAX  = 5'd10;
   localparam logic [15:0] DIV12_RECIP = 16'd171;

   // Event queue between the parser and the write sequencer.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_CMD  = 2'd0,
      PH_NOTE = 2'd1,
      PH_VEL  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      BEAT_FNUM_HI = 2'd0,
      BEAT_FNUM_LO = 2'd1,
      BEAT_KEY_OFF = 2'd2,
      BEAT_KEY_SET = 2'd3
   } beat_type;

   // One note event, already reduced to the values the four writes need.
   typedef struct packed {
      logic [7:0] hi_value;
      logic [7:0] lo_value;
      logic       key_on;
   } mnfm_evt_type;

   typedef struct packed {
      logic         valid;
      mnfm_evt_type evt;
   } mnfm_slot_type;

   // F-number of the middle octave for each pitch class, in 1/32 steps.
   function automatic logic [15:0] fnum_rom(input logic [3:0] idx);
      logic [15:0] val;
      unique case (idx)
         4'd0:    val = 16'd20927;
         4'd1:    val = 16'd22173;
         4'd2:    val = 16'd23487;
         4'd3:    val = 16'd24883;
         4'd4:    val = 16'd26363;
         4'd5:    val = 16'd27934;
         4'd6:    val = 16'd29595;
         4'd7:    val = 16'd31331;
         4'd8:    val = 16'd33218;
         4'd9:    val = 16'd35196;
         4'd10:   val = 16'd37288;
         4'd11:   val = 16'd39507;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mnfm_req_if.sv =====
// ----------------------------------------------------------------------------
// MIDI byte channel
// Valid/ready channel carrying one received MIDI byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mnfm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] midi_byte;

   modport source (output valid, output midi_byte, input ready);
   modport sink   (input valid, input midi_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/mnfm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Synth register write channel
// Valid/ready channel carrying one register address and value per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mnfm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reg_addr;
   logic [7:0] reg_value;
   logic       last_write;

   modport source (output valid, output reg_addr, output reg_value, output last_write,
                   input ready);
   modport sink   (input valid, input reg_addr, input reg_value, input last_write,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/mnfm_front.sv =====
// ----------------------------------------------------------------------------
// Note-on parser
// Tracks the three-byte note-on message and pushes one event per velocity.
// ----------------------------------------------------------------------------
`default_nettype none

module mnfm_front
   import mnfm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   mnfm_req_if.sink      req_ch,
   input  logic          queue_full,
   output mnfm_slot_type push
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  held_idx_ff, held_idx_in;
   logic [3:0]  held_shift_ff, held_shift_in;

   logic        accept;
   logic [15:0] div_prod;
   logic [4:0]  octave;
   logic [7:0]  octave_x12;
   logic [7:0]  pitch_full;
   logic [15:0] fnum;

   assign accept = req_ch.valid && req_ch.ready;

   // Note split into octave and pitch class, done when the note byte arrives.
   assign div_prod   = {8'd0, req_ch.midi_byte} * DIV12_RECIP;
   assign octave     = div_prod[15:11];
   assign octave_x12 = {octave, 3'b000} + {1'b0, octave, 2'b00};
   assign pitch_full = req_ch.midi_byte - octave_x12;

   assign held_idx_in   = pitch_full[3:0];
   assign held_shift_in = (octave > OCTAVE_MAX) ? 4'd0 : 4'(OCTAVE_MAX - octave);

   assign fnum = fnum_rom(held_idx_ff) >> held_shift_ff;

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_NOTE: phase_in = PH_VEL;
            PH_VEL:  phase_in = PH_CMD;
            default: phase_in = (req_ch.midi_byte == CMD_NOTE_ON) ? PH_NOTE : PH_CMD;
         endcase
      end
   end

   always_comb begin
      req_ch.ready     = 1'b1;
      push.valid       = 1'b0;
      push.evt.hi_value = BLOCK_BITS + fnum[15:8];
      push.evt.lo_value = fnum[7:0];
      push.evt.key_on   = (req_ch.midi_byte != 8'd0);
      unique case (phase_ff)
         PH_VEL: begin
            req_ch.ready = !queue_full;
            push.valid   = req_ch.valid && !queue_full;
         end
         default: begin
            req_ch.ready = 1'b1;
            push.valid   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CMD;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && phase_ff == PH_NOTE) begin
         held_idx_ff   <= held_idx_in;
         held_shift_ff <= held_shift_in;
      end
   end

   // A pushed event always comes from a velocity byte that was accepted.
   a_push_from_velocity: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (accept && phase_ff == PH_VEL))
      else $error("event pushed outside the velocity phase");

   // After a note byte the parser always expects the velocity.
   a_note_then_vel: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_NOTE) |=> (phase_ff == PH_VEL))
      else $error("parser did not advance to the velocity phase");

endmodule

`default_nettype wire

// ===== rtl/mnfm_queue.sv =====
// ----------------------------------------------------------------------------
// Note event queue
// Small FIFO of decoded note events between the parser and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mnfm_queue
   import mnfm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  mnfm_slot_type push,
   output logic          full,
   output mnfm_slot_type head,
   input  logic          pop
);

   mnfm_evt_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.evt   = slot_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   assign wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
   assign count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.evt;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

   // The parser must never offer an event the queue cannot take.
   a_no_lost_push: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && full))
      else $error("event pushed into a full queue");

endmodule

`default_nettype wire

// ===== rtl/mnfm_back.sv =====
// ----------------------------------------------------------------------------
// Register write sequencer
// Turns each queued note event into four synth register write beats.
// ----------------------------------------------------------------------------
`default_nettype none

module mnfm_back
   import mnfm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  mnfm_slot_type head,
   output logic          pop,
   mnfm_rsp_if.source    rsp_ch
);

   mnfm_evt_type evt_ff, evt_in;
   logic         busy_ff, busy_in;
   beat_type     beat_ff, beat_in;
   logic         accept;
   logic         final_beat;

   assign accept     = rsp_ch.valid && rsp_ch.ready;
   assign final_beat = accept && (beat_ff == BEAT_KEY_SET);
   assign pop        = head.valid && (!busy_ff || final_beat);
   assign evt_in     = head.evt;

   // Next beat.
   always_comb begin
      busy_in = busy_ff;
      beat_in = beat_ff;
      if (pop) begin
         busy_in = 1'b1;
         beat_in = BEAT_FNUM_HI;
      end else if (final_beat) begin
         busy_in = 1'b0;
         beat_in = BEAT_FNUM_HI;
      end else if (accept) begin
         unique case (beat_ff)
            BEAT_FNUM_HI: beat_in = BEAT_FNUM_LO;
            BEAT_FNUM_LO: beat_in = BEAT_KEY_OFF;
            BEAT_KEY_OFF: beat_in = BEAT_KEY_SET;
            BEAT_KEY_SET: beat_in = BEAT_FNUM_HI;
         endcase
      end
   end

   // Beat payload.
   always_comb begin
      rsp_ch.valid      = busy_ff;
      rsp_ch.last_write = 1'b0;
      unique case (beat_ff)
         BEAT_FNUM_HI: begin
            rsp_ch.reg_addr  = REG_FNUM_HI;
            rsp_ch.reg_value = evt_ff.hi_value;
         end
         BEAT_FNUM_LO: begin
            rsp_ch.reg_addr  = REG_FNUM_LO;
            rsp_ch.reg_value = evt_ff.lo_value;
         end
         BEAT_KEY_OFF: begin
            rsp_ch.reg_addr  = REG_KEY;
            rsp_ch.reg_value = KEY_OFF_ALL;
         end
         BEAT_KEY_SET: begin
            rsp_ch.reg_addr   = REG_KEY;
            rsp_ch.reg_value  = evt_ff.key_on ? KEY_ON_ALL : KEY_OFF_ALL;
            rsp_ch.last_write = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= BEAT_FNUM_HI;
      end else begin
         busy_ff <= busy_in;
         beat_ff <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         evt_ff <= evt_in;
      end
   end

   // A stalled beat keeps its place in the sequence.
   a_beat_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> (busy_ff && $stable(beat_ff)))
      else $error("write sequence moved while stalled");

   // Every event starts with the F-number high write.
   a_event_starts: assert property (@(posedge clock) disable iff (reset)
      pop |=> (busy_ff && beat_ff == BEAT_FNUM_HI))
      else $error("event did not start at the first write");

endmodule

`default_nettype wire

// ===== rtl/midi_note_to_fm_register_writes.sv =====
// ----------------------------------------------------------------------------
// MIDI note-on to FM synth register writes
// Parses note-on messages from a MIDI byte stream and issues the pitch and
// key register writes for each note.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat carries
//   -------  ---------  ------------------------------------------------
//   req_ch   in         midi_byte: status, note number or velocity
//   rsp_ch   out        reg_addr, reg_value, last_write (fourth write)
//
// A MIDI byte is taken every cycle while the parser is not holding a
// velocity byte in front of a full event queue. Each velocity byte gives
// four write beats, back to back while the sink is ready: the sequencer
// emits one beat per cycle and takes the next event when the last write
// of the current one is accepted. A taken velocity byte's event goes into
// the queue and then into the sequencer's event register before the first
// write is offered. Reset is synchronous and active high; it returns the
// parser to waiting for a note-on status byte and empties the queue.
// A stalled sink only fills the four-entry queue; bytes that give no
// writes keep flowing until a velocity byte meets a full queue.
//
`default_nettype none

module midi_note_to_fm_register_writes
   import mnfm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mnfm_req_if.sink    req_ch,
   mnfm_rsp_if.source  rsp_ch
);

   // Decoded note events pass from parser to sequencer through the queue,
   // so a stalled register sink blocks bytes only once a velocity byte meets
   // a full queue, and a slow MIDI source never starves an event in flight.
   mnfm_slot_type push;
   mnfm_slot_type head;
   logic          queue_full;
   logic          pop;

   // The parser classifies each byte by phase. A note byte is split into
   // octave and pitch class right away, so the velocity byte only needs a
   // table lookup and a shift to form the F-number.
   mnfm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push)
   );

   mnfm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // The sequencer holds one event in a register and walks it through the
   // pitch-high, pitch-low, key-off and key-set writes. It takes the next
   // event in the same cycle its last write is accepted.
   mnfm_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for the MIDI note-on to FM register write block
// Sends a MIDI byte stream of directed and random note-on messages mixed
// with stray bytes, predicts the four register writes of every note event,
// and checks each write beat in order while both channels stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mnfm_pkg::*;

   // Cycles before the run is declared hung.
   localparam int CYCLE_LIMIT = 100000;
   // Length of the single long stall on the write channel.
   localparam int LONG_HOLD = 80;
   // Cycles to keep watching after the last expected write has arrived.
   localparam int DRAIN_CYCLES = 16;
   // Bytes at the end of the stream during which nobody idles.
   localparam int CALM_TAIL = 30;

   // Middle-octave F-numbers of the twelve pitch classes, scaled by 32.
   localparam logic [15:0] PITCH_Q32 [12] = '{
      16'd20927, 16'd22173, 16'd23487, 16'd24883, 16'd26363, 16'd27934,
      16'd29595, 16'd31331, 16'd33218, 16'd35196, 16'd37288, 16'd39507
   };

   typedef struct packed {
      logic [7:0] addr;
      logic [7:0] value;
      logic       last;
   } fm_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mnfm_req_if req_ch ();
   mnfm_rsp_if rsp_ch ();

   midi_note_to_fm_register_writes u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // Parser state of the predictor, kept in step with accepted beats.
   phase_type  parse_state;
   logic [7:0] held_note;

   // Register writes still owed by the block, oldest first.
   fm_write_type expected_writes[$];
   // MIDI bytes waiting to be offered on the input channel.
   logic [7:0]   midi_stream[$];

   int  bytes_taken   = 0;
   int  bytes_total   = 0;
   int  error_count   = 0;
   int  cycle_count   = 0;
   bit  req_took      = 1'b0;
   int  req_idle_left = 0;
   int  rsp_idle_left = 0;
   int  rsp_hold_left = 0;
   bit  hold_done     = 1'b0;

   // F-number of a note: the pitch-class entry shifted down by how far the
   // octave lies below the top one. Octaves past the top are clamped.
   function automatic logic [15:0] note_fnum(input logic [7:0] note);
      logic [7:0] octave;
      logic [3:0] pitch;
      octave = note / 8'd12;
      pitch  = 4'(note % 8'd12);
      if (octave > 8'(OCTAVE_MAX))
         octave = 8'(OCTAVE_MAX);
      return PITCH_Q32[pitch] >> (8'(OCTAVE_MAX) - octave);
   endfunction

   // Advances the parser by one accepted byte. A velocity byte queues the
   // four writes of the note event: pitch high, pitch low, key off, key set.
   function automatic void take_midi_byte(input logic [7:0] midi_byte);
      logic [15:0] fnum;
      case (parse_state)
         PH_NOTE: begin
            held_note   = midi_byte;
            parse_state = PH_VEL;
         end
         PH_VEL: begin
            parse_state = PH_CMD;
            fnum = note_fnum(held_note);
            expected_writes.push_back('{REG_FNUM_HI, BLOCK_BITS + fnum[15:8], 1'b0});
            expected_writes.push_back('{REG_FNUM_LO, fnum[7:0], 1'b0});
            expected_writes.push_back('{REG_KEY, KEY_OFF_ALL, 1'b0});
            expected_writes.push_back('{REG_KEY,
                                        (midi_byte != 8'd0) ? KEY_ON_ALL : KEY_OFF_ALL,
                                        1'b1});
         end
         // Waiting for a command; anything but a note-on status is dropped.
         default: begin
            parse_state = (midi_byte == CMD_NOTE_ON) ? PH_NOTE : PH_CMD;
         end
      endcase
   endfunction

   // Random idling is allowed except in the last stretch of the stream and
   // in every third window of 24 bytes, which gives runs at full speed. The
   // sender also keeps going around the long write stall, so that the block
   // really fills up and pushes back on its input.
   function automatic bit idling_allowed(input bit for_sender);
      if (bytes_taken >= bytes_total - CALM_TAIL)
         return 1'b0;
      if ((bytes_taken / 24) % 3 == 2)
         return 1'b0;
      if (for_sender && bytes_taken >= 96 && bytes_taken < 140)
         return 1'b0;
      return 1'b1;
   endfunction

   task automatic queue_note_on(input logic [7:0] note, input logic [7:0] velocity);
      midi_stream.push_back(CMD_NOTE_ON);
      midi_stream.push_back(note);
      midi_stream.push_back(velocity);
   endtask

   // Monitor: everything is sampled at the rising edge. Accepted MIDI beats
   // feed the predictor, and each accepted write beat is compared with the
   // oldest write still owed.
   always @(posedge clock) begin
      fm_write_type want;
      req_took = 1'b0;
      if (reset) begin
         parse_state = PH_CMD;
         held_note   = 8'd0;
         expected_writes.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            take_midi_byte(req_ch.midi_byte);
            bytes_taken++;
            req_took = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_writes.size() == 0) begin
               $error("unexpected write beat: reg_addr=%h reg_value=%h last_write=%b",
                      rsp_ch.reg_addr, rsp_ch.reg_value, rsp_ch.last_write);
               error_count++;
            end else begin
               want = expected_writes.pop_front();
               if (rsp_ch.reg_addr !== want.addr) begin
                  $error("reg_addr mismatch: expected %h, actual %h",
                         want.addr, rsp_ch.reg_addr);
                  error_count++;
               end
               if (rsp_ch.reg_value !== want.value) begin
                  $error("reg_value mismatch: expected %h, actual %h",
                         want.value, rsp_ch.reg_value);
                  error_count++;
               end
               if (rsp_ch.last_write !== want.last) begin
                  $error("last_write mismatch: expected %b, actual %b",
                         want.last, rsp_ch.last_write);
                  error_count++;
               end
            end
         end
      end
   end

   // Driver: inputs change at the falling edge. A new byte is offered only
   // once the previous beat has been taken, and valid stays up between
   // back-to-back beats.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.midi_byte <= 8'd0;
      end else if (!req_ch.valid || req_took) begin
         if (req_idle_left > 0) begin
            req_idle_left--;
            req_ch.valid <= 1'b0;
         end else if (idling_allowed(1'b1) && $urandom_range(0, 3) == 0) begin
            req_idle_left = $urandom_range(0, 4);
            req_ch.valid <= 1'b0;
         end else if (midi_stream.size() != 0) begin
            req_ch.valid     <= 1'b1;
            req_ch.midi_byte <= midi_stream.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Write sink: ready changes at the falling edge. Once, about halfway
   // through, it holds ready low for a long stretch; otherwise it stalls in
   // short random bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && bytes_taken >= 100) begin
         hold_done     = 1'b1;
         rsp_hold_left = LONG_HOLD - 1;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_idle_left > 0) begin
         rsp_idle_left--;
         rsp_ch.ready <= 1'b0;
      end else if (idling_allowed(1'b0) && $urandom_range(0, 3) == 0) begin
         rsp_idle_left = $urandom_range(0, 4);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Watchdog against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int pick;
      logic [7:0] note;
      logic [7:0] velocity;

      req_ch.valid     = 1'b0;
      req_ch.midi_byte = 8'd0;
      rsp_ch.ready     = 1'b0;

      // Directed part. Stray bytes while waiting for a command, including
      // both all-zero and all-one bytes and a note-on for another channel,
      // must give nothing.
      midi_stream.push_back(8'h00);
      midi_stream.push_back(8'hFF);
      midi_stream.push_back(8'h80);
      midi_stream.push_back(8'h91);
      // Lowest note with zero velocity, so the key stays off.
      queue_note_on(8'd0, 8'd0);
      // Highest ordinary MIDI note and velocity.
      queue_note_on(8'd127, 8'd127);
      // Largest byte as the note: octave far past the table, clamped.
      queue_note_on(8'hFF, 8'd1);
      // Status bytes are taken as plain data in the note and velocity slots.
      queue_note_on(CMD_NOTE_ON, CMD_NOTE_ON);
      // Last note of the top octave, then the first one beyond it.
      queue_note_on(8'd131, 8'h80);
      queue_note_on(8'd132, 8'h40);

      // Random part: mostly well-formed note-ons with random content, some
      // with notes and velocities across the whole byte range, mixed with
      // stray bytes and note-ons whose data bytes are arbitrary.
      while (midi_stream.size() < 180) begin
         pick = $urandom_range(0, 9);
         if (pick <= 6) begin
            note = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 127));
            case ($urandom_range(0, 5))
               0:       velocity = 8'd0;
               1:       velocity = 8'($urandom_range(0, 255));
               default: velocity = 8'($urandom_range(1, 127));
            endcase
            queue_note_on(note, velocity);
         end else if (pick <= 8) begin
            // A stray byte; it is dropped unless it happens to be a note-on.
            midi_stream.push_back(8'($urandom_range(0, 255)));
         end else begin
            queue_note_on(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
      end
      bytes_total = midi_stream.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Wait for every byte to be taken and every owed write to arrive, then
      // keep watching a little longer for writes that should not come.
      while (bytes_taken < bytes_total || expected_writes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
